### rtl/http_body_deframer_macros.svh
// Assertion macros used by the checker file of the body deframer.
`ifndef HTTP_BODY_DEFRAMER_MACROS_SVH
`define HTTP_BODY_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HBD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("body deframer check failed");

// Next-cycle implication, disabled while reset is high.
`define HBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("body deframer check failed");

`endif

### rtl/hbd_pkg.sv
// Package with the shared types, codes and helpers of the body deframer.
`timescale 1ns / 1ps

package hbd_pkg;

   // Body framing modes.
   localparam logic [1:0] MODE_CHUNKED = 2'd0;
   localparam logic [1:0] MODE_LENGTH  = 2'd1;
   localparam logic [1:0] MODE_CLOSE   = 2'd2;

   // Error codes reported on the result channel.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NO_DIGITS = 2'd1;
   localparam logic [1:0] ERR_DELIM     = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BODY_MODE   = 2'd0;
   localparam logic [1:0] CSR_BODY_LENGTH = 2'd1;

   // Line delimiters.
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Configuration as seen by the decoder.
   typedef struct packed {
      logic [1:0]  body_mode;
      logic [31:0] body_length;
   } cfg_type;

   // One word held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } in_word_type;

   // Result of a hex digit lookup.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Decodes one ASCII hex digit, either case.
   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h61 + 8'd10);
      end
      return h;
   endfunction

endpackage

### rtl/hbd_in_stage.sv
// Input register stage of the body deframer.
`timescale 1ns / 1ps

module hbd_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               advance,
   output hbd_pkg::in_word_type in_word
);

   logic       valid_ff;
   logic [7:0] byte_ff;

   // The register takes a new word when empty or when its word moves on.
   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   // The byte itself needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_in_byte;
      end
   end

   assign in_word.valid = valid_ff;
   assign in_word.data  = byte_ff;

endmodule

### rtl/hbd_decoder.sv
// Framing state machine and result register of the body deframer.
`timescale 1ns / 1ps

module hbd_decoder #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hbd_pkg::cfg_type     cfg,
   input  hbd_pkg::in_word_type in_word,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_payload_valid,
   output logic                 rsp_body_done,
   output logic [1:0]           rsp_error_code
);

   // The counter also serves as the byte count in length mode.
   localparam int CNT_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
   localparam logic [CNT_W-1:0] SIZE_MASK = {CNT_W{1'b1}} >> (CNT_W - LENGTH_BITS);

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             digit_seen_ff, digit_seen_in;
   logic             in_ext_ff, in_ext_in;
   logic             finished_ff, finished_in;
   logic [1:0]       error_ff, error_in;
   logic             payload_in;

   logic             rsp_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             payload_ff;
   logic             done_ff;
   logic [1:0]       err_out_ff;

   logic             fire;
   logic [7:0]       c;
   hbd_pkg::hex_type hex;
   logic [CNT_W-1:0] len_ext;
   logic [CNT_W-1:0] count_shift;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W-1:0] count_inc;
   logic             below_len;

   // A word is consumed whenever the result register is free or drains.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = in_word.valid && advance;
   assign c       = in_word.data;
   assign hex     = hbd_pkg::hex_value(c);

   // Arithmetic shared by the framing cases.
   assign len_ext     = CNT_W'(cfg.body_length);
   assign count_shift = CNT_W'({count_ff[LENGTH_BITS-5:0], hex.value});
   assign count_dec   = (count_ff - CNT_W'(1)) & SIZE_MASK;
   assign count_inc   = count_ff + CNT_W'(1);
   assign below_len   = count_ff < len_ext;

   // Next state and result for the word in the input register.
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      digit_seen_in = digit_seen_ff;
      in_ext_in     = in_ext_ff;
      finished_in   = finished_ff;
      error_in      = error_ff;
      payload_in    = 1'b0;
      if (error_ff == hbd_pkg::ERR_NONE && !finished_ff) begin
         case (cfg.body_mode)
            hbd_pkg::MODE_CHUNKED: begin
               case (phase_ff)
                  PH_SIZE: begin
                     if (in_ext_ff) begin
                        if (c == hbd_pkg::CH_CR) phase_in = PH_SIZE_LF;
                     end else if (hex.ok) begin
                        if (count_ff[LENGTH_BITS-1 -: 4] != 4'd0) begin
                           error_in = hbd_pkg::ERR_OVERFLOW;
                        end else begin
                           count_in      = count_shift;
                           digit_seen_in = 1'b1;
                        end
                     end else if (!digit_seen_ff) begin
                        error_in = hbd_pkg::ERR_NO_DIGITS;
                     end else if (c == hbd_pkg::CH_CR) begin
                        phase_in = PH_SIZE_LF;
                     end else begin
                        in_ext_in = 1'b1;
                     end
                  end
                  PH_SIZE_LF: begin
                     if (c != hbd_pkg::CH_LF) begin
                        error_in = hbd_pkg::ERR_DELIM;
                     end else if (count_ff == '0) begin
                        finished_in = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     count_in   = count_dec;
                     payload_in = 1'b1;
                     if (count_dec == '0) phase_in = PH_DATA_CR;
                  end
                  PH_DATA_CR: begin
                     if (c != hbd_pkg::CH_CR) error_in = hbd_pkg::ERR_DELIM;
                     else phase_in = PH_DATA_LF;
                  end
                  PH_DATA_LF: begin
                     if (c != hbd_pkg::CH_LF) begin
                        error_in = hbd_pkg::ERR_DELIM;
                     end else begin
                        phase_in      = PH_SIZE;
                        count_in      = '0;
                        digit_seen_in = 1'b0;
                        in_ext_in     = 1'b0;
                     end
                  end
                  default: begin
                     phase_in = PH_SIZE;
                  end
               endcase
            end
            hbd_pkg::MODE_LENGTH: begin
               // Pass bytes until the count reaches the declared length.
               if (below_len) begin
                  payload_in  = 1'b1;
                  count_in    = count_inc;
                  finished_in = (count_inc == len_ext);
               end else begin
                  finished_in = 1'b1;
               end
            end
            default: begin
               payload_in = 1'b1;
            end
         endcase
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         count_ff      <= '0;
         digit_seen_ff <= 1'b0;
         in_ext_ff     <= 1'b0;
         finished_ff   <= 1'b0;
         error_ff      <= hbd_pkg::ERR_NONE;
         rsp_valid_ff  <= 1'b0;
         out_byte_ff   <= 8'd0;
         payload_ff    <= 1'b0;
         done_ff       <= 1'b0;
         err_out_ff    <= hbd_pkg::ERR_NONE;
      end else if (fire) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         digit_seen_ff <= digit_seen_in;
         in_ext_ff     <= in_ext_in;
         finished_ff   <= finished_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= 1'b1;
         out_byte_ff   <= payload_in ? c : 8'd0;
         payload_ff    <= payload_in;
         done_ff       <= finished_in;
         err_out_ff    <= error_in;
      end else if (rsp_ready) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_payload_valid = payload_ff;
   assign rsp_body_done     = done_ff;
   assign rsp_error_code    = err_out_ff;

endmodule

### rtl/http_body_deframer.sv
// Top level of the HTTP/1.1 body deframer: chunked, length and close modes.
//
//   Channel   Direction  Ports                            Word
//   req       in         req_valid req_ready req_in_byte  one body byte
//   rsp       out        rsp_valid rsp_ready rsp_*        payload byte and status
//   csr       in         csr_valid csr_ready csr_index    register write
//                        csr_data
//
// One byte is accepted per cycle while rsp_ready is high; each accepted byte
// waits in the input register and its result is then loaded into the result
// register. The rate is set by the state update of the decoder. Reset clears the
// framing state, errors and both registers; config returns to chunked mode with
// length zero. When rsp_ready is low the result holds and the input register
// still takes one more byte, if it is empty, before req_ready drops.
`timescale 1ns / 1ps

module http_body_deframer #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_body_done,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0]           body_mode_ff;
   logic [31:0]          body_length_ff;
   hbd_pkg::cfg_type     cfg;
   hbd_pkg::in_word_type in_word;
   logic                 advance;

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff   <= hbd_pkg::MODE_CHUNKED;
         body_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hbd_pkg::CSR_BODY_MODE:   body_mode_ff   <= csr_data[1:0];
            hbd_pkg::CSR_BODY_LENGTH: body_length_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.body_mode   = body_mode_ff;
   assign cfg.body_length = body_length_ff;

   hbd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .in_word     (in_word)
   );

   hbd_decoder #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_decoder (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_word           (in_word),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_body_done     (rsp_body_done),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

### rtl/hbd_checker.sv
// Port-level checks of the body deframer and their binding to the top level.
`timescale 1ns / 1ps
`include "http_body_deframer_macros.svh"

module hbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_payload_valid,
   input logic        rsp_body_done,
   input logic [1:0]  rsp_error_code
);

   // A stalled result word holds its value.
   `HBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_error_code))

   // A word that is not payload carries a zero byte.
   `HBD_ASSERT_IMP(a_zero_byte, clock, reset, rsp_valid && !rsp_payload_valid,
      rsp_out_byte == 8'd0)

   // An error blocks payload and completion.
   `HBD_ASSERT_IMP(a_err_quiet, clock, reset,
      rsp_valid && rsp_error_code != hbd_pkg::ERR_NONE,
      !rsp_payload_valid && !rsp_body_done)

   // A finished body never reports an error.
   `HBD_ASSERT_IMP(a_done_clean, clock, reset, rsp_valid && rsp_body_done,
      rsp_error_code == hbd_pkg::ERR_NONE)

   // Errors stay until reset: the next word carries the same code.
   `HBD_ASSERT_NEXT(a_err_sticky, clock, reset,
      rsp_valid && rsp_ready && rsp_error_code != hbd_pkg::ERR_NONE,
      !rsp_valid || rsp_error_code == $past(rsp_error_code))

endmodule

bind http_body_deframer hbd_checker u_hbd_checker (.*);

### tb/tb_http_body_deframer.sv
// Self-checking testbench for the HTTP body deframer in all three framing modes.
`timescale 1ns / 1ps

module tb_http_body_deframer;

   // Codes that the package leaves unnamed: the spare mode and a spare register index.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] CSR_SPARE  = 2'd3;
   localparam int RANDOM_ITEMS = 600;
   localparam int LONG_HOLD    = 400;

   // Framing phases of the chunked decoder.
   typedef enum logic [2:0] {
      FR_SIZE, FR_SIZE_LF, FR_DATA, FR_DATA_CR, FR_DATA_LF
   } frame_phase_type;

   // One result word as the block reports it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       payload_valid;
      logic       body_done;
      logic [1:0] error_code;
   } deframe_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_payload_valid;
   logic        rsp_body_done;
   logic [1:0]  rsp_error_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   http_body_deframer #(.LENGTH_BITS(32)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_body_done     (rsp_body_done),
      .rsp_error_code    (rsp_error_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Body bytes waiting to be sent and result words predicted for them.
   logic [7:0]       tx_bytes[$];
   deframe_word_type predicted_results[$];
   int               items_made = 0;
   int               mismatch_count = 0;

   // Handshake bookkeeping shared between the clock edges.
   bit in_fired = 1'b0;
   bit out_fired = 1'b0;
   int in_gap = 0;
   int out_gap = 0;
   bit no_idle = 1'b0;
   bit hold_go = 1'b0;
   bit rsp_hold = 1'b0;

   // Shadow configuration and framing state of the decoder.
   logic [1:0]      cfg_mode = hbd_pkg::MODE_CHUNKED;
   logic [31:0]     cfg_length = 32'd0;
   frame_phase_type fr_phase = FR_SIZE;
   logic [31:0]     fr_count = 32'd0;
   bit              fr_digit = 1'b0;
   bit              fr_ext = 1'b0;
   bit              fr_done = 1'b0;
   logic [1:0]      fr_err = hbd_pkg::ERR_NONE;

   initial begin
      forever #5 clock = ~clock;
   end

   // Value of an ASCII hex digit, or -1 for any other byte.
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   // Advances the chunked framing by one byte; returns 1 when the byte is payload.
   function automatic bit chunked_step(input logic [7:0] c);
      int hv;
      hv = hex_digit(c);
      case (fr_phase)
         FR_SIZE: begin
            if (fr_ext) begin
               if (c == hbd_pkg::CH_CR) fr_phase = FR_SIZE_LF;
               return 1'b0;
            end
            if (hv >= 0) begin
               // A digit that would push set bits out of the size is an overflow.
               if (fr_count[31:28] != 4'd0) begin
                  fr_err = hbd_pkg::ERR_OVERFLOW;
                  return 1'b0;
               end
               fr_count = {fr_count[27:0], 4'(hv)};
               fr_digit = 1'b1;
               return 1'b0;
            end
            if (!fr_digit) begin
               fr_err = hbd_pkg::ERR_NO_DIGITS;
               return 1'b0;
            end
            if (c == hbd_pkg::CH_CR) fr_phase = FR_SIZE_LF;
            else fr_ext = 1'b1;
            return 1'b0;
         end
         FR_SIZE_LF: begin
            if (c != hbd_pkg::CH_LF) begin
               fr_err = hbd_pkg::ERR_DELIM;
               return 1'b0;
            end
            if (fr_count == 32'd0) fr_done = 1'b1;
            else fr_phase = FR_DATA;
            return 1'b0;
         end
         FR_DATA: begin
            fr_count = fr_count - 32'd1;
            if (fr_count == 32'd0) fr_phase = FR_DATA_CR;
            return 1'b1;
         end
         FR_DATA_CR: begin
            if (c != hbd_pkg::CH_CR) fr_err = hbd_pkg::ERR_DELIM;
            else fr_phase = FR_DATA_LF;
            return 1'b0;
         end
         default: begin
            if (c != hbd_pkg::CH_LF) begin
               fr_err = hbd_pkg::ERR_DELIM;
               return 1'b0;
            end
            fr_phase = FR_SIZE;
            fr_count = 32'd0;
            fr_digit = 1'b0;
            fr_ext = 1'b0;
            return 1'b0;
         end
      endcase
   endfunction

   // Expected result word for one accepted body byte, in the current mode.
   function automatic deframe_word_type predict_word(input logic [7:0] c);
      deframe_word_type w;
      bit pass;
      pass = 1'b0;
      if (fr_err == hbd_pkg::ERR_NONE && !fr_done) begin
         if (cfg_mode == hbd_pkg::MODE_CHUNKED) begin
            pass = chunked_step(c);
         end else if (cfg_mode == hbd_pkg::MODE_LENGTH) begin
            if (fr_count < cfg_length) begin
               pass = 1'b1;
               fr_count = fr_count + 32'd1;
            end
            if (fr_count >= cfg_length) fr_done = 1'b1;
         end else begin
            pass = 1'b1;
         end
      end
      w.out_byte = pass ? c : 8'h00;
      w.payload_valid = pass;
      w.body_done = fr_done;
      w.error_code = fr_err;
      return w;
   endfunction

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Result check first, then the prediction for a newly accepted byte.
   always @(posedge clock) begin
      deframe_word_type want;
      out_fired = !reset && rsp_valid && rsp_ready;
      if (out_fired) begin
         if (predicted_results.size() == 0) begin
            $error("result word arrived with no prediction pending");
            mismatch_count++;
         end else begin
            want = predicted_results.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_payload_valid !== want.payload_valid) begin
               $error("payload_valid: expected %0b, got %0b",
                      want.payload_valid, rsp_payload_valid);
               mismatch_count++;
            end
            if (rsp_body_done !== want.body_done) begin
               $error("body_done: expected %0b, got %0b", want.body_done, rsp_body_done);
               mismatch_count++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code, rsp_error_code);
               mismatch_count++;
            end
         end
      end
      in_fired = !reset && req_valid && req_ready;
      if (in_fired) predicted_results.push_back(predict_word(req_in_byte));
   end

   // Sender: one word at a time from the byte queue, after a random gap.
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (in_fired) begin
         next_valid = 1'b0;
         in_gap = draw_gap();
      end
      if (!reset && !next_valid) begin
         if (in_gap > 0) begin
            in_gap = in_gap - 1;
         end else if (tx_bytes.size() != 0) begin
            req_in_byte <= tx_bytes.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: random stall before each word, plus the long hold when asked.
   always @(negedge clock) begin
      if (out_fired) out_gap = draw_gap();
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (out_gap > 0) begin
         out_gap = out_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long receiver hold, counted here while the sender keeps offering words.
   initial begin
      wait (hold_go);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic push_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      items_made++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] byte_other_than(input logic [7:0] x);
      logic [7:0] b;
      b = 8'($urandom());
      while (b == x) b = 8'($urandom());
      return b;
   endfunction

   function automatic logic [7:0] non_hex_byte(input bit allow_cr);
      logic [7:0] b;
      b = 8'($urandom());
      while (hex_digit(b) >= 0 || (!allow_cr && b == hbd_pkg::CH_CR)) b = 8'($urandom());
      return b;
   endfunction

   function automatic int pick_chunk_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(16, 48);
      return $urandom_range(1, 8);
   endfunction

   // Optional extension, then the CR LF that closes a size line.
   task automatic push_line_end(input bit with_ext);
      if (with_ext) begin
         push_byte(non_hex_byte(1'b0));
         repeat ($urandom_range(0, 5)) push_byte(byte_other_than(hbd_pkg::CH_CR));
      end
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
   endtask

   // Size line in hex with random case and up to two leading zeros.
   task automatic push_size_line(input logic [31:0] chunk_len, input bit with_ext);
      logic [3:0] d;
      bit started;
      started = 1'b0;
      repeat ($urandom_range(0, 2)) push_byte(hex_char(4'd0));
      for (int i = 7; i >= 0; i--) begin
         d = chunk_len[i*4 +: 4];
         if (d != 4'd0 || started || i == 0) begin
            push_byte(hex_char(d));
            started = 1'b1;
         end
      end
      push_line_end(with_ext);
   endtask

   task automatic push_chunk(input logic [31:0] chunk_len, input bit with_ext);
      push_size_line(chunk_len, with_ext);
      repeat (chunk_len) push_byte(8'($urandom()));
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
   endtask

   // Waits until every queued word is sent and every predicted result has come.
   task automatic drain();
      while (tx_bytes.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == hbd_pkg::CSR_BODY_MODE) cfg_mode = value[1:0];
      else if (idx == hbd_pkg::CSR_BODY_LENGTH) cfg_length = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mode writes carry random upper bits, which the block must ignore.
   task automatic set_mode(input logic [1:0] mode);
      csr_write(hbd_pkg::CSR_BODY_MODE, {30'($urandom()), mode});
   endtask

   // Bytes after the end of the body or an error, offered in one mode.
   task automatic push_tail(input logic [1:0] mode);
      set_mode(mode);
      repeat (4) push_byte(8'($urandom()));
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      drain();
   endtask

   // Main sequence: directed words, random chunked traffic, one terminal event.
   initial begin
      int kind;
      int k;
      int part;
      logic [3:0] d;
      logic [31:0] chunk_len;
      bit first_phase;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Close mode passes every byte, delimiters included.
      set_mode(hbd_pkg::MODE_CLOSE);
      csr_write(hbd_pkg::CSR_BODY_LENGTH, 32'hFFFF_FFFF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      push_byte(8'h30);
      push_byte(8'h55);
      push_byte(8'hAA);
      drain();

      // The spare register index is ignored and the spare mode acts as close mode.
      csr_write(CSR_SPARE, $urandom());
      set_mode(MODE_SPARE);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h41);
      drain();

      // Two short chunks: a plain one and one with a leading zero and an extension.
      set_mode(hbd_pkg::MODE_CHUNKED);
      csr_write(hbd_pkg::CSR_BODY_LENGTH, 32'd0);
      push_byte(8'h31);
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      push_byte(8'hFF);
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      push_byte(8'h30);
      push_byte(8'h32);
      push_byte(8'h3B);
      push_byte(hbd_pkg::CH_LF);
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(hbd_pkg::CH_CR);
      push_byte(hbd_pkg::CH_LF);
      drain();

      // Random well-formed chunks with mode changes between and inside them.
      items_made = 0;
      first_phase = 1'b1;
      while (items_made < RANDOM_ITEMS) begin
         no_idle = first_phase || ($urandom_range(0, 3) == 0);
         if (first_phase) hold_go = 1'b1;
         repeat (first_phase ? 12 : $urandom_range(3, 10))
            push_chunk(pick_chunk_len(), $urandom_range(0, 2) == 0);
         first_phase = 1'b0;
         drain();
         kind = $urandom_range(0, 3);
         case (kind)
            0: begin
               // Close-mode stretch between chunks.
               set_mode($urandom_range(0, 1) ? hbd_pkg::MODE_CLOSE : MODE_SPARE);
               repeat ($urandom_range(5, 20)) push_byte(8'($urandom()));
               drain();
               set_mode(hbd_pkg::MODE_CHUNKED);
            end
            1: begin
               // Length mode leaves a count behind that the next size line extends.
               csr_write(hbd_pkg::CSR_BODY_LENGTH, $urandom() | 32'h100);
               set_mode(hbd_pkg::MODE_LENGTH);
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom()));
               drain();
               set_mode(hbd_pkg::MODE_CHUNKED);
               d = 4'($urandom());
               chunk_len = {fr_count[27:0], d};
               push_byte(hex_char(d));
               push_line_end($urandom_range(0, 1));
               repeat (chunk_len) push_byte(8'($urandom()));
               push_byte(hbd_pkg::CH_CR);
               push_byte(hbd_pkg::CH_LF);
               drain();
            end
            2: begin
               // Mode change in the middle of chunk data.
               chunk_len = $urandom_range(4, 12);
               part = $urandom_range(1, chunk_len - 1);
               push_size_line(chunk_len, $urandom_range(0, 1));
               repeat (part) push_byte(8'($urandom()));
               drain();
               set_mode($urandom_range(0, 1) ? hbd_pkg::MODE_CLOSE : MODE_SPARE);
               repeat ($urandom_range(3, 10)) push_byte(8'($urandom()));
               drain();
               set_mode(hbd_pkg::MODE_CHUNKED);
               repeat (chunk_len - part) push_byte(8'($urandom()));
               push_byte(hbd_pkg::CH_CR);
               push_byte(hbd_pkg::CH_LF);
               drain();
            end
            default: begin
               csr_write(hbd_pkg::CSR_BODY_LENGTH, $urandom());
            end
         endcase
      end

      // One terminal event per run: the end of the body or a sticky error.
      no_idle = 1'b0;
      kind = $urandom_range(0, 7);
      case (kind)
         0: begin
            push_size_line(32'd0, $urandom_range(0, 1));
         end
         1: begin
            k = $urandom_range(2, 20);
            csr_write(hbd_pkg::CSR_BODY_LENGTH, k);
            set_mode(hbd_pkg::MODE_LENGTH);
            repeat (k + 5) push_byte(8'($urandom()));
         end
         2: begin
            // Zero length: the first byte is dropped and ends the body.
            csr_write(hbd_pkg::CSR_BODY_LENGTH, 32'd0);
            set_mode(hbd_pkg::MODE_LENGTH);
         end
         3: begin
            push_byte($urandom_range(0, 1) ? hbd_pkg::CH_CR : non_hex_byte(1'b1));
         end
         4: begin
            push_byte(hex_char(4'($urandom_range(1, 15))));
            push_byte(hbd_pkg::CH_CR);
            push_byte(byte_other_than(hbd_pkg::CH_LF));
         end
         5: begin
            push_size_line(32'd2, 1'b0);
            repeat (2) push_byte(8'($urandom()));
            push_byte(byte_other_than(hbd_pkg::CH_CR));
         end
         6: begin
            push_size_line(32'd2, 1'b0);
            repeat (2) push_byte(8'($urandom()));
            push_byte(hbd_pkg::CH_CR);
            push_byte(byte_other_than(hbd_pkg::CH_LF));
         end
         default: begin
            // Nine digits: the last one would shift the top nibble out.
            push_byte(hex_char(4'($urandom_range(1, 15))));
            repeat (8) push_byte(hex_char(4'($urandom())));
         end
      endcase
      repeat (4) push_byte(8'($urandom()));
      drain();

      // Nothing passes after the terminal event, whatever the mode.
      push_tail(hbd_pkg::MODE_CHUNKED);
      push_tail(hbd_pkg::MODE_LENGTH);
      push_tail(hbd_pkg::MODE_CLOSE);
      push_tail(MODE_SPARE);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
